[hw/rtl/dttd_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal text to double package
// Shared types, character codes and the fraction place weight table.
// ----------------------------------------------------------------------------
package dttd_pkg;

  localparam int unsigned MAX_FRACTION_DIGITS = 9;
  localparam logic [31:0] WHOLE_LIMIT_RESET   = 32'd30000000;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [5:0]  FRAC_BITS = 6'd52;
  localparam logic [10:0] EXP_OFFSET = 11'd991;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_WHOLE = 4'b0100,
    PH_FRAC  = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        negative;
    logic [31:0] whole;
    logic [32:0] frac_sum;
    logic [3:0]  frac_count;
    logic        frac_nonzero;
    logic        range_failed;
    logic        dropped_nonzero;
    logic        syntax_failed;
  } tok_t;

  localparam tok_t TOK_RESET = '{
    phase:           PH_START,
    negative:        1'b0,
    whole:           32'd0,
    frac_sum:        33'd0,
    frac_count:      4'd0,
    frac_nonzero:    1'b0,
    range_failed:    1'b0,
    dropped_nonzero: 1'b0,
    syntax_failed:   1'b0
  };

  // 2^32 * 10^-(idx+1), rounded to nearest for every idx but 6, which holds 430 (rounded up).
  function automatic logic [31:0] place_weight(input logic [3:0] idx);
    logic [31:0] w;
    case (idx)
      4'd0:    w = 32'd429496730;
      4'd1:    w = 32'd42949673;
      4'd2:    w = 32'd4294967;
      4'd3:    w = 32'd429497;
      4'd4:    w = 32'd42950;
      4'd5:    w = 32'd4295;
      4'd6:    w = 32'd430;
      4'd7:    w = 32'd43;
      4'd8:    w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/decimal_text_to_double.sv]
// After the edge that takes the last character, the token moves through the converter's
// registered stages in order; m_axis_tvalid rises when it reaches the last of them.
// One character per cycle while s_axis_tready is high; a full, stalled converter drops it.
// The token scanner folds one accepted character a cycle; a four-stage converter follows.
// Reset clears the token state and all stage valid bits; whole_limit returns to 30000000.
// ----------------------------------------------------------------------------
// Decimal text to double
// Parses a decimal number token character by character into binary64 bits.
// ----------------------------------------------------------------------------
module decimal_text_to_double #(
  parameter int unsigned MaxFracDigits = dttd_pkg::MAX_FRACTION_DIGITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // [0] number_valid, [1] over_limit, [65:2] value_bits
);

  logic [31:0]    limit_q;
  logic           in_accept;
  dttd_pkg::tok_t tok_next;
  logic           conv_ready;
  logic           nv, oor;
  logic [63:0]    bits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= dttd_pkg::WHOLE_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = conv_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  dttd_scan #(
    .MaxFracDigits(MaxFracDigits)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .last_i  (s_axis_tlast),
    .char_i  (s_axis_tdata),
    .limit_i (limit_q),
    .tok_o   (tok_next)
  );

  dttd_conv u_conv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (in_accept && s_axis_tlast),
    .tok_i         (tok_next),
    .limit_i       (limit_q),
    .ready_o       (conv_ready),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .number_valid_o(nv),
    .over_limit_o  (oor),
    .value_bits_o  (bits)
  );

  assign m_axis_tdata = {6'd0, bits, oor, nv};

`ifndef SYNTHESIS
  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> limit_q == $past(cfg_data_i))
    else $error("configuration write not taken into the limit register");
`endif

endmodule

[hw/rtl/dttd_scan.sv]
// ----------------------------------------------------------------------------
// Token scanner
// Holds the parse state of the current token and folds in one character.
// ----------------------------------------------------------------------------
module dttd_scan #(
  parameter int unsigned MaxFracDigits = dttd_pkg::MAX_FRACTION_DIGITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           last_i,
  input  logic [7:0]     char_i,
  input  logic [31:0]    limit_i,
  output dttd_pkg::tok_t tok_o
);

  dttd_pkg::tok_t tok_q, tok_d;
  logic           is_digit;
  logic [3:0]     digit;
  logic [7:0]     char_off;
  logic [35:0]    whole_prod;
  logic           whole_over;
  logic [35:0]    frac_prod;
  logic           frac_keep;
  logic           do_whole;
  logic           do_frac;

  assign is_digit   = (char_i >= dttd_pkg::CH_ZERO) && (char_i <= dttd_pkg::CH_NINE);
  assign char_off   = char_i - dttd_pkg::CH_ZERO;
  assign digit      = is_digit ? char_off[3:0] : 4'd0;
  assign whole_prod = ({4'd0, tok_q.whole} << 3) + ({4'd0, tok_q.whole} << 1) + 36'(digit);
  assign whole_over = whole_prod > {4'd0, limit_i};
  assign frac_prod  = 36'(digit) * 36'(dttd_pkg::place_weight(tok_q.frac_count));
  assign frac_keep  = !tok_q.range_failed && (tok_q.frac_count < 4'(MaxFracDigits));

  always_comb begin
    tok_d    = tok_q;
    do_whole = 1'b0;
    do_frac  = 1'b0;
    if (!tok_q.syntax_failed) begin
      unique case (tok_q.phase)
        dttd_pkg::PH_START: begin
          if (char_i == dttd_pkg::CH_MINUS || char_i == dttd_pkg::CH_PLUS) begin
            tok_d.negative = (char_i == dttd_pkg::CH_MINUS);
            tok_d.phase    = dttd_pkg::PH_SIGN;
          end else if (is_digit) begin
            do_whole    = 1'b1;
            tok_d.phase = dttd_pkg::PH_WHOLE;
          end else begin
            tok_d.syntax_failed = 1'b1;
          end
        end
        dttd_pkg::PH_SIGN: begin
          if (is_digit) begin
            do_whole    = 1'b1;
            tok_d.phase = dttd_pkg::PH_WHOLE;
          end else begin
            tok_d.syntax_failed = 1'b1;
          end
        end
        dttd_pkg::PH_WHOLE: begin
          if (is_digit) begin
            do_whole = 1'b1;
          end else if (char_i == dttd_pkg::CH_POINT) begin
            tok_d.phase = dttd_pkg::PH_FRAC;
          end else begin
            tok_d.syntax_failed = 1'b1;
          end
        end
        dttd_pkg::PH_FRAC: begin
          if (is_digit) begin
            do_frac = 1'b1;
          end else begin
            tok_d.syntax_failed = 1'b1;
          end
        end
        default: tok_d.syntax_failed = 1'b1;
      endcase
    end
    if (do_whole) begin
      if (whole_over) begin
        tok_d.range_failed = 1'b1;
      end else if (!tok_q.range_failed) begin
        tok_d.whole = whole_prod[31:0];
      end
    end
    if (do_frac) begin
      if (frac_keep) begin
        tok_d.frac_sum = tok_q.frac_sum + frac_prod[32:0];
        if (digit != 4'd0) begin
          tok_d.frac_nonzero = 1'b1;
        end
      end else if (digit != 4'd0) begin
        tok_d.dropped_nonzero = 1'b1;
      end
      if (tok_q.frac_count != 4'd15) begin
        tok_d.frac_count = tok_q.frac_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= dttd_pkg::TOK_RESET;
    end else if (accept_i) begin
      tok_q <= last_i ? dttd_pkg::TOK_RESET : tok_d;
    end
  end

  assign tok_o = tok_d;

`ifndef SYNTHESIS
  a_tok_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> tok_q == dttd_pkg::TOK_RESET)
    else $error("token state not cleared after last character");

  a_frac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.phase != dttd_pkg::PH_FRAC |-> tok_q.frac_count == 4'd0 && tok_q.frac_sum == 33'd0)
    else $error("fraction state active outside the fraction phase");
`endif

endmodule

[hw/rtl/dttd_conv.sv]
// ----------------------------------------------------------------------------
// Value converter
// Checks a finished token and turns its 32.32 value into binary64 bits.
// ----------------------------------------------------------------------------
module dttd_conv (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dttd_pkg::tok_t tok_i,
  input  logic [31:0]    limit_i,
  output logic           ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           number_valid_o,
  output logic           over_limit_o,
  output logic [63:0]    value_bits_o
);

  logic rdy1, rdy2, rdy3, rdy4;

  logic           v1_q;
  dttd_pkg::tok_t tok1_q;

  logic        v2_q, nv2_q, oor2_q, neg2_q;
  logic [63:0] val2_q;
  logic        nv2_d, oor2_d;
  logic [63:0] val2_d;
  logic [31:0] upper;

  logic        v3_q, nv3_q, oor3_q, neg3_q, zero3_q;
  logic [63:0] val3_q;
  logic [5:0]  msb3_q, msb_d;
  logic [63:0] scan;

  logic        v4_q, nv4_q, oor4_q;
  logic [63:0] bits4_q, bits_d;
  logic [63:0] lsh_val, rsh_val, half_bit, low_mask;
  logic [5:0]  lsh_amt, rsh_amt;
  logic        round_up;
  logic [53:0] mant;
  logic [51:0] frac_field;
  logic [10:0] exp_field;
  logic        carry;

  assign rdy4    = !v4_q || out_ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // Syntax and range verdict, then the fixed-point value.
  always_comb begin
    nv2_d  = !tok1_q.syntax_failed &&
             (tok1_q.phase == dttd_pkg::PH_WHOLE ||
              (tok1_q.phase == dttd_pkg::PH_FRAC && tok1_q.frac_count != 4'd0));
    oor2_d = nv2_d && (tok1_q.range_failed || tok1_q.whole > limit_i ||
             (tok1_q.whole == limit_i && (tok1_q.frac_nonzero || tok1_q.dropped_nonzero)));
    upper  = tok1_q.whole + 32'(tok1_q.frac_sum[32]);
    val2_d = (nv2_d && !oor2_d) ? {upper, tok1_q.frac_sum[31:0]} : 64'd0;
  end

  // Position of the leading one, found by halving the word.
  always_comb begin
    scan  = val2_q;
    msb_d = 6'd0;
    for (int i = 5; i >= 0; i--) begin
      if ((scan >> (1 << i)) != 64'd0) begin
        msb_d[i] = 1'b1;
        scan     = scan >> (1 << i);
      end
    end
  end

  // Normalize and round to nearest, ties to even.
  always_comb begin
    lsh_amt    = dttd_pkg::FRAC_BITS - msb3_q;
    rsh_amt    = msb3_q - dttd_pkg::FRAC_BITS;
    lsh_val    = val3_q << lsh_amt;
    rsh_val    = val3_q >> rsh_amt;
    half_bit   = 64'd1 << (rsh_amt - 6'd1);
    low_mask   = half_bit - 64'd1;
    round_up   = 1'b0;
    mant       = {1'b0, lsh_val[52:0]};
    if (msb3_q > dttd_pkg::FRAC_BITS) begin
      round_up = ((val3_q & half_bit) != 64'd0) &&
                 (((val3_q & low_mask) != 64'd0) || rsh_val[0]);
      mant     = rsh_val[53:0] + 54'(round_up);
    end
    carry      = mant[53];
    frac_field = carry ? 52'd0 : mant[51:0];
    exp_field  = 11'(msb3_q) + dttd_pkg::EXP_OFFSET + 11'(carry);
    bits_d     = zero3_q ? 64'd0 : {neg3_q, exp_field, frac_field};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= push_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && push_i) begin
      tok1_q <= tok_i;
    end
    if (rdy2 && v1_q) begin
      nv2_q  <= nv2_d;
      oor2_q <= oor2_d;
      neg2_q <= tok1_q.negative;
      val2_q <= val2_d;
    end
    if (rdy3 && v2_q) begin
      nv3_q   <= nv2_q;
      oor3_q  <= oor2_q;
      neg3_q  <= neg2_q;
      val3_q  <= val2_q;
      msb3_q  <= msb_d;
      zero3_q <= (val2_q == 64'd0);
    end
    if (rdy4 && v3_q) begin
      nv4_q   <= nv3_q;
      oor4_q  <= oor3_q;
      bits4_q <= bits_d;
    end
  end

  assign out_valid_o    = v4_q;
  assign number_valid_o = nv4_q;
  assign over_limit_o   = oor4_q;
  assign value_bits_o   = bits4_q;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("token pushed while the first stage is blocked");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rdy4 |=> v4_q)
    else $error("item lost between rounding and output stages");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && oor4_q |-> nv4_q && bits4_q == 64'd0)
    else $error("out-of-range result carries a value");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !nv4_q |-> !oor4_q && bits4_q == 64'd0)
    else $error("invalid token result carries a value or range flag");
`endif

endmodule

[sim/decimal_text_to_double_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to double checker
// Watches the configuration, character and result channels and keeps its own
// model of the token scanner. It predicts each number on the marked character
// and compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module decimal_text_to_double_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_char_i,   // [7:0] character
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [71:0] out_data_i,  // [0] number_valid, [1] over_limit, [65:2] value_bits
  output int          fail_count_o,
  output int          pending_o
);

  localparam int MANT_BITS      = 52;
  localparam int EXP_BIAS       = 1023;
  localparam int FRAC_COUNT_MAX = 15;

  typedef struct packed {
    logic        number_valid;
    logic        over_limit;
    logic [63:0] value_bits;
  } number_result_t;

  number_result_t   expected_numbers[$];
  number_result_t   want;
  logic [31:0]      whole_limit;
  dttd_pkg::phase_e scan_phase;
  logic             negative_sign;
  logic [31:0]      whole_value;
  logic [63:0]      frac_sum;
  logic [3:0]       frac_count;
  logic             frac_nonzero;
  logic             range_failed;
  logic             dropped_nonzero;
  logic             syntax_failed;

  function automatic logic [31:0] frac_weight(input int place);
    logic [31:0] w;
    case (place)
      0:       w = 32'd429496730;
      1:       w = 32'd42949673;
      2:       w = 32'd4294967;
      3:       w = 32'd429497;
      4:       w = 32'd42950;
      5:       w = 32'd4295;
      6:       w = 32'd430;
      7:       w = 32'd43;
      8:       w = 32'd4;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] fixed_to_double(input logic neg, input logic [63:0] q);
    int          msb;
    int          expo;
    int          sh;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    if (q == 64'd0) return 64'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (q[i]) msb = i;
    expo = msb - 32;
    if (msb <= MANT_BITS) begin
      mant = q << (MANT_BITS - msb);
    end else begin
      sh   = msb - MANT_BITS;
      mant = q >> sh;
      rem  = q & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
      if (mant[MANT_BITS+1]) begin
        mant = mant >> 1;
        expo++;
      end
    end
    bits = {neg, 11'(expo + EXP_BIAS), mant[MANT_BITS-1:0]};
    return bits;
  endfunction

  task automatic clear_token();
    scan_phase      = dttd_pkg::PH_START;
    negative_sign   = 1'b0;
    whole_value     = 32'd0;
    frac_sum        = 64'd0;
    frac_count      = 4'd0;
    frac_nonzero    = 1'b0;
    range_failed    = 1'b0;
    dropped_nonzero = 1'b0;
    syntax_failed   = 1'b0;
  endtask

  task automatic add_whole_digit(input logic [31:0] d);
    if (whole_limit < d || whole_value > (whole_limit - d) / 32'd10) begin
      range_failed = 1'b1;
    end else if (!range_failed) begin
      whole_value = whole_value * 32'd10 + d;
    end
  endtask

  task automatic scan_character(input logic [7:0] ch, input logic last);
    logic           is_digit;
    logic [31:0]    d;
    number_result_t res;
    is_digit = (ch >= dttd_pkg::CH_ZERO) && (ch <= dttd_pkg::CH_NINE);
    d = is_digit ? 32'(ch - dttd_pkg::CH_ZERO) : 32'd0;
    if (!syntax_failed) begin
      case (scan_phase)
        dttd_pkg::PH_START: begin
          if (ch == dttd_pkg::CH_MINUS || ch == dttd_pkg::CH_PLUS) begin
            negative_sign = (ch == dttd_pkg::CH_MINUS);
            scan_phase = dttd_pkg::PH_SIGN;
          end else if (is_digit) begin
            add_whole_digit(d);
            scan_phase = dttd_pkg::PH_WHOLE;
          end else begin
            syntax_failed = 1'b1;
          end
        end
        dttd_pkg::PH_SIGN: begin
          if (is_digit) begin
            add_whole_digit(d);
            scan_phase = dttd_pkg::PH_WHOLE;
          end else begin
            syntax_failed = 1'b1;
          end
        end
        dttd_pkg::PH_WHOLE: begin
          if (is_digit) add_whole_digit(d);
          else if (ch == dttd_pkg::CH_POINT) scan_phase = dttd_pkg::PH_FRAC;
          else syntax_failed = 1'b1;
        end
        default: begin
          if (is_digit) begin
            if (!range_failed && frac_count < dttd_pkg::MAX_FRACTION_DIGITS) begin
              frac_sum = frac_sum + 64'(d) * 64'(frac_weight(int'(frac_count)));
              if (d != 32'd0) frac_nonzero = 1'b1;
            end else if (d != 32'd0) begin
              dropped_nonzero = 1'b1;
            end
            if (frac_count < FRAC_COUNT_MAX) frac_count = frac_count + 4'd1;
          end else begin
            syntax_failed = 1'b1;
          end
        end
      endcase
    end
    if (last) begin
      res.number_valid = !syntax_failed && (scan_phase == dttd_pkg::PH_WHOLE ||
                         (scan_phase == dttd_pkg::PH_FRAC && frac_count != 4'd0));
      res.over_limit   = res.number_valid && (range_failed || whole_value > whole_limit ||
                         (whole_value == whole_limit && (frac_nonzero || dropped_nonzero)));
      res.value_bits = (res.number_valid && !res.over_limit) ?
                       fixed_to_double(negative_sign, {whole_value, 32'd0} + frac_sum) : 64'd0;
      expected_numbers.push_back(res);
      clear_token();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_limit = dttd_pkg::WHOLE_LIMIT_RESET;
      clear_token();
      expected_numbers.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) whole_limit = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_numbers.size() == 0) begin
          $error("result item with no number pending: %h", out_data_i);
          fail_count_o++;
        end else begin
          want = expected_numbers.pop_front();
          if (out_data_i[0] !== want.number_valid) begin
            $error("number_valid: expected %0d, actual %0d", want.number_valid, out_data_i[0]);
            fail_count_o++;
          end
          if (out_data_i[1] !== want.over_limit) begin
            $error("over_limit: expected %0d, actual %0d", want.over_limit, out_data_i[1]);
            fail_count_o++;
          end
          if (out_data_i[65:2] !== want.value_bits) begin
            $error("value_bits: expected %h, actual %h", want.value_bits, out_data_i[65:2]);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) scan_character(in_char_i, in_last_i);
      pending_o = expected_numbers.size();
    end
  end

endmodule

[sim/tb_decimal_text_to_double.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to double testbench
// Feeds directed and random number tokens one character per item under
// several whole limits and idle mixes on both streams. The checker beside
// the block predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_double;

  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_CHARS  = 215;
  localparam int DRAIN_CYCLES = 8;
  localparam int FINAL_CYCLES = 20;

  typedef enum int {
    DIGITS_ANY,
    DIGITS_ZERO,
    DIGITS_NINE
  } digit_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] character
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // [0] number_valid, [1] over_limit, [65:2] value_bits

  int          fail_count;
  int          pending_numbers;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          token_total;
  int          char_total;
  int          phase_chars;
  logic [7:0]  token_chars[$];
  logic [31:0] limit_now;
  logic [31:0] phase_limits[PHASE_COUNT];

  decimal_text_to_double dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  decimal_text_to_double_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_char_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_numbers)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("decimal_text_to_double regression: fail");
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    char_total++;
    phase_chars++;
  endtask

  task automatic send_token();
    for (int i = 0; i < token_chars.size(); i++) begin
      send_char(token_chars[i], i == token_chars.size() - 1);
    end
    token_total++;
    token_chars.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
    send_token();
  endtask

  task automatic append_digits(input int count, input digit_mode_e mode);
    for (int i = 0; i < count; i++) begin
      case (mode)
        DIGITS_ZERO: token_chars.push_back(dttd_pkg::CH_ZERO);
        DIGITS_NINE: token_chars.push_back(dttd_pkg::CH_NINE);
        default:     token_chars.push_back(dttd_pkg::CH_ZERO + 8'($urandom_range(9)));
      endcase
    end
  endtask

  // The block is only reconfigured once every number has left it.
  task automatic set_limit(input logic [31:0] value, input int src_pct, input int sink_pct);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_numbers != 0) @(negedge clk_i);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_now = value;
  endtask

  task automatic build_random_token();
    int          kind;
    digit_mode_e mode;
    string       s;
    logic [31:0] near;
    kind = $urandom_range(99);
    if (kind < 12) begin
      case ($urandom_range(2))
        0:       near = limit_now;
        1:       near = limit_now - 32'd1;
        default: near = limit_now + 32'd1;
      endcase
      if ($urandom_range(1)) begin
        token_chars.push_back($urandom_range(1) ? dttd_pkg::CH_MINUS : dttd_pkg::CH_PLUS);
      end
      s = $sformatf("%0d", near);
      for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
      if ($urandom_range(1)) begin
        token_chars.push_back(dttd_pkg::CH_POINT);
        append_digits($urandom_range(12, 1), $urandom_range(1) ? DIGITS_ZERO : DIGITS_ANY);
      end
    end else begin
      case ($urandom_range(9))
        0:       mode = DIGITS_NINE;
        1, 2:    mode = DIGITS_ZERO;
        default: mode = DIGITS_ANY;
      endcase
      case ($urandom_range(2))
        0:       token_chars.push_back(dttd_pkg::CH_MINUS);
        1:       token_chars.push_back(dttd_pkg::CH_PLUS);
        default: ;
      endcase
      append_digits(($urandom_range(99) < 15) ? $urandom_range(12, 5) : $urandom_range(4, 1),
                    mode);
      if ($urandom_range(99) < 60) begin
        token_chars.push_back(dttd_pkg::CH_POINT);
        append_digits(($urandom_range(99) < 25) ? $urandom_range(18, 10) :
                      $urandom_range(4, 1), mode);
      end
      if (kind >= 80) begin
        case ($urandom_range(4))
          0: begin
            token_chars.delete();
            repeat ($urandom_range(6, 1)) token_chars.push_back(8'($urandom_range(255)));
          end
          1: token_chars[$urandom_range(token_chars.size() - 1)] = 8'($urandom_range(255));
          2: token_chars.push_back(dttd_pkg::CH_POINT);
          3: token_chars.push_front(dttd_pkg::CH_POINT);
          default: begin
            token_chars.delete();
            case ($urandom_range(2))
              0:       token_chars.push_back(dttd_pkg::CH_MINUS);
              1:       token_chars.push_back(dttd_pkg::CH_PLUS);
              default: token_chars.push_back(dttd_pkg::CH_POINT);
            endcase
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 32'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tlast  <= 1'b0;
    src_idle_pct  = 38;
    sink_idle_pct = 75;
    token_total   = 0;
    char_total    = 0;
    phase_chars   = 0;
    limit_now     = dttd_pkg::WHOLE_LIMIT_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limit: signed zero, a plain value and the syntax faults.
    send_text("-0");
    send_text("+1.5");
    send_text("5.");
    send_text("-");
    token_chars.push_back(8'hff);
    send_token();
    token_chars.push_back(8'h00);
    send_token();
    send_text("3x4");

    // Limit of 10: equal, above, and equal with a fraction.
    set_limit(32'd10, 38, 75);
    send_text("10");
    send_text("10.5");
    send_text("11");
    send_text("-10.0");

    phase_limits[0] = 32'd10;
    phase_limits[1] = 32'hffff_ffff;
    phase_limits[2] = ($urandom() < 10) ? 32'd10 : 32'($urandom());
    phase_limits[3] = 32'($urandom_range(9999, 10));
    phase_limits[4] = dttd_pkg::WHOLE_LIMIT_RESET;
    phase_limits[5] = 32'd1000000;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 2) set_limit(phase_limits[p], 38, 75);
      else if (p < 4) set_limit(phase_limits[p], 75, 38);
      else set_limit(phase_limits[p], 0, 0);
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        build_random_token();
        send_token();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_numbers != 0) @(negedge clk_i);
    repeat (FINAL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d tokens in %0d characters under whole limits from 10 to 4294967295,",
             token_total, char_total);
    $display("with idle on either stream, both, and neither.");
    if (fail_count == 0 && pending_numbers == 0) begin
      $display("decimal_text_to_double regression: pass");
    end else begin
      $display("decimal_text_to_double regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dttd_pkg.sv
hw/rtl/dttd_scan.sv
hw/rtl/dttd_conv.sv
hw/rtl/decimal_text_to_double.sv
sim/decimal_text_to_double_checker.sv
sim/tb_decimal_text_to_double.sv
